[hw/rtl/mhpq_pkg.sv]
// Shared types and codes for the max-heap priority queue.
// Payload structs, status codes and controller-to-datapath command/status.
// No dependencies.
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int KEY_W          = 32;
    localparam int FILL_W         = 11;
    localparam int ST_W           = 2;
    localparam int HEAP_DEPTH_DEF = 1024;

    // operation field
    localparam logic OPER_INSERT  = 1'b0;
    localparam logic OPER_EXTRACT = 1'b1;

    // status field
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // datapath operations
    localparam int DP_OP_W = 4;
    localparam logic [DP_OP_W-1:0] DP_NOP   = 4'd0;
    localparam logic [DP_OP_W-1:0] DP_INS   = 4'd1;  // latch key, hole at end
    localparam logic [DP_OP_W-1:0] DP_EXT   = 4'd2;  // read root and last
    localparam logic [DP_OP_W-1:0] DP_LOAD  = 4'd3;  // capture max, last key
    localparam logic [DP_OP_W-1:0] DP_UPRD  = 4'd4;  // read parent
    localparam logic [DP_OP_W-1:0] DP_UPCMP = 4'd5;  // compare, move parent down
    localparam logic [DP_OP_W-1:0] DP_DNRD  = 4'd6;  // read both children
    localparam logic [DP_OP_W-1:0] DP_DNCMP = 4'd7;  // compare, move child up
    localparam logic [DP_OP_W-1:0] DP_HOME  = 4'd8;  // write key into the hole
    localparam logic [DP_OP_W-1:0] DP_FULL  = 4'd9;
    localparam logic [DP_OP_W-1:0] DP_EMPTY = 4'd10;

    typedef struct packed {
        logic                    operation;
        logic signed [KEY_W-1:0] key;
    } mhpq_in_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] max_key;
        logic [ST_W-1:0]         status;
        logic [FILL_W-1:0]       fill_count;
    } mhpq_out_t;

    typedef struct packed {
        logic [DP_OP_W-1:0] op;
        logic               out_load;
    } mhpq_cmd_t;

    typedef struct packed {
        logic is_full;     // count == depth
        logic is_empty;    // count == 0
        logic up_gt;       // held key > parent read data
        logic par_root;    // parent of hole is the root
        logic left_oob;    // left child of hole beyond count
        logic child_pick;  // a child beats the held key
    } mhpq_stat_t;

endpackage

[hw/rtl/max_heap_priority_queue_core.sv]
// Top level of the binary max-heap priority queue (insert / extract-max).
// Depends on mhpq_pkg, mhpq_ctrl, mhpq_dp (which holds mhpq_ram).
//
//  channel | handshake            | beat payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | mhpq_in_t  {operation, key}
//  out     | out_valid / out_ready| mhpq_out_t {max_key, status, fill_count}
//
// One beat in gives exactly one beat out. The steps of each item:
//   insert  : latch the key with the hole at the end, then a registered parent
//             read and a compare/write per level the key climbs; the key is
//             written into the hole where it stops; empty heap: latch, write.
//   extract : read root and last, load them, then a registered read of both
//             children and a compare/write per level the replacement sinks;
//             last key: no sift. Full-heap insert, empty extract: status only.
// Datapath reset clears only the count; the key store holds no reset value and
// no entry at or above the count is ever used. The finished result sits in an
// output register, so the next beat is accepted while out_ready is low; the
// sequencer only waits when a second result is ready and the first is untaken.
`timescale 1ns / 1ps

module max_heap_priority_queue_core #(
    parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mhpq_pkg::mhpq_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mhpq_pkg::mhpq_out_t out_data
);
    import mhpq_pkg::*;

    mhpq_cmd_t  cmd;
    mhpq_stat_t stat;

    // sequencer: picks the datapath operation for each cycle
    mhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (in_data.operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // key store, hole pointer, count and result register
    mhpq_dp #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .out_data (out_data),
        .cmd      (cmd),
        .stat     (stat)
    );

    // heap can never be both full and empty
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({stat.is_full, stat.is_empty}))
        else $error("heap reports full and empty at once");

    // one item in flight: ready drops right after an accepted beat
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat accepted while busy");

    // insert into a full heap must be dropped
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_data.operation == OPER_INSERT) && stat.is_full)
        |-> (cmd.op == DP_FULL))
        else $error("insert into full heap not dropped");

    // empty extract reports a zero key
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == ST_EMPTY)) |-> (out_data.max_key == '0))
        else $error("empty extract returned a nonzero key");

endmodule

[hw/rtl/mhpq_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[hw/rtl/mhpq_ctrl.sv]
// Heap sequencer: walks sift-up / sift-down, read then compare per level.
// Depends on mhpq_pkg.
`timescale 1ns / 1ps

module mhpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_op,
    output logic                out_valid,
    input  logic                out_ready,
    output mhpq_pkg::mhpq_cmd_t cmd,
    input  mhpq_pkg::mhpq_stat_t stat
);
    import mhpq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UPRD  = 3'd1;
    localparam logic [2:0] S_UPCMP = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_DNRD  = 3'd4;
    localparam logic [2:0] S_DNCMP = 3'd5;
    localparam logic [2:0] S_HOME  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = DP_NOP;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == OPER_INSERT)
                    begin
                        if (stat.is_full)
                        begin
                            cmd.op     = DP_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = DP_INS;
                            state_next = stat.is_empty ? S_HOME : S_UPRD;
                        end
                    end
                    else
                    begin
                        if (stat.is_empty)
                        begin
                            cmd.op     = DP_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = DP_EXT;
                            state_next = S_LOAD;
                        end
                    end
                end
            end
            S_UPRD:
            begin
                cmd.op     = DP_UPRD;
                state_next = S_UPCMP;
            end
            S_UPCMP:
            begin
                cmd.op = DP_UPCMP;
                if (stat.up_gt)
                begin
                    state_next = stat.par_root ? S_HOME : S_UPRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LOAD:
            begin
                // count is already decremented here
                cmd.op     = DP_LOAD;
                state_next = stat.is_empty ? S_DONE : S_DNRD;
            end
            S_DNRD:
            begin
                if (stat.left_oob)
                begin
                    cmd.op     = DP_HOME;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_DNRD;
                    state_next = S_DNCMP;
                end
            end
            S_DNCMP:
            begin
                cmd.op     = DP_DNCMP;
                state_next = stat.child_pick ? S_DNRD : S_DONE;
            end
            S_HOME:
            begin
                cmd.op     = DP_HOME;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/mhpq_dp.sv]
// Heap datapath: key store RAM, hole position, element count, result register.
// Depends on mhpq_pkg and mhpq_ram.
`timescale 1ns / 1ps

module mhpq_dp #(
    parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mhpq_pkg::mhpq_in_t   in_data,
    output mhpq_pkg::mhpq_out_t  out_data,
    input  mhpq_pkg::mhpq_cmd_t  cmd,
    output mhpq_pkg::mhpq_stat_t stat
);
    import mhpq_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int LW = AW + 2;

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] max_reg, max_next;
    logic [ST_W-1:0]         status_reg, status_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [CW-1:0]           count_reg, count_next;
    mhpq_out_t               out_reg;

    logic                    we;
    logic [AW-1:0]           waddr, raddr_a, raddr_b;
    logic [KEY_W-1:0]        wdata, rdata_a, rdata_b;

    logic [AW-1:0]           parent;
    logic [LW-1:0]           left_w, right_w, count_w;
    logic                    right_ok, left_gt, right_gt, up_gt;
    logic signed [KEY_W-1:0] best_val;

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (HEAP_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        parent   = (pos_reg - AW'(1)) >> 1;
        left_w   = {1'b0, pos_reg, 1'b1};
        right_w  = {1'b0, pos_reg, 1'b0} + LW'(2);
        count_w  = LW'(count_reg);
        right_ok = (right_w < count_w);
        left_gt  = ($signed(rdata_a) > key_reg);
        best_val = left_gt ? $signed(rdata_a) : key_reg;
        right_gt = right_ok && ($signed(rdata_b) > best_val);
        // sift-up: held key must strictly beat its parent to climb
        up_gt    = (key_reg > $signed(rdata_a));

        stat.is_full    = (count_reg == CW'(HEAP_DEPTH));
        stat.is_empty   = (count_reg == '0);
        stat.up_gt      = up_gt;
        stat.par_root   = (parent == '0);
        stat.left_oob   = (left_w >= count_w);
        stat.child_pick = left_gt || right_gt;
    end

    always_comb
    begin
        key_next    = key_reg;
        max_next    = max_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = key_reg;
        raddr_a     = parent;
        raddr_b     = right_w[AW-1:0];
        unique case (cmd.op)
            DP_NOP:
            begin
            end
            DP_INS:
            begin
                key_next    = in_data.key;
                max_next    = '0;
                status_next = ST_OK;
                pos_next    = count_reg[AW-1:0];
                count_next  = count_reg + CW'(1);
            end
            DP_EXT:
            begin
                raddr_a     = '0;
                raddr_b     = AW'(count_reg - CW'(1));
                status_next = ST_OK;
                count_next  = count_reg - CW'(1);
            end
            DP_LOAD:
            begin
                max_next = $signed(rdata_a);
                key_next = $signed(rdata_b);
                pos_next = '0;
            end
            DP_UPRD:
            begin
                raddr_a = parent;
            end
            DP_UPCMP:
            begin
                if (up_gt)
                begin
                    // parent moves down into the hole
                    we       = 1'b1;
                    wdata    = rdata_a;
                    pos_next = parent;
                end
                else
                begin
                    we = 1'b1;
                end
            end
            DP_DNRD:
            begin
                raddr_a = left_w[AW-1:0];
                raddr_b = right_w[AW-1:0];
            end
            DP_DNCMP:
            begin
                we = 1'b1;
                if (right_gt)
                begin
                    wdata    = rdata_b;
                    pos_next = right_w[AW-1:0];
                end
                else if (left_gt)
                begin
                    wdata    = rdata_a;
                    pos_next = left_w[AW-1:0];
                end
            end
            DP_HOME:
            begin
                we = 1'b1;
            end
            DP_FULL:
            begin
                max_next    = '0;
                status_next = ST_FULL;
            end
            DP_EMPTY:
            begin
                max_next    = '0;
                status_next = ST_EMPTY;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        max_reg    <= max_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        if (cmd.out_load)
        begin
            out_reg.max_key    <= max_reg;
            out_reg.status     <= status_reg;
            out_reg.fill_count <= FILL_W'(count_reg);
        end
    end

    assign out_data = out_reg;

endmodule

[dv/max_heap_priority_queue_core_tb.sv]
// Self-checking testbench for max_heap_priority_queue_core (insert / extract-max heap).
// Depends on mhpq_pkg and the core RTL. A scoreboard heap predicts every result beat.
`timescale 1ns / 1ps

module max_heap_priority_queue_core_tb;

    import mhpq_pkg::*;

    localparam int DEPTH          = HEAP_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {
        RX_ALWAYS  = 2'd0,
        RX_MOSTLY  = 2'd1,
        RX_PERIOD  = 2'd2,
        RX_SPARSE  = 2'd3
    } rx_mode_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    mhpq_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    mhpq_out_t out_data;

    // stimulus and scoreboard
    mhpq_in_t  pending_ops[$];
    mhpq_out_t expected_results[$];
    int        gen_fill;
    int        mismatch_count;

    // scoreboard copy of the heap
    logic signed [KEY_W-1:0] heap_model_keys [DEPTH];
    int                      heap_model_fill;

    // sender burst / gap control
    int burst_left;
    int gap_left;

    // receiver stall pattern
    rx_mode_t rx_mode;
    int       rx_timer;

    int idle_cycles;

    max_heap_priority_queue_core #(
        .HEAP_DEPTH(DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Scoreboard heap: insert sifts up, extract moves last to root and sifts down
    // (left child wins ties, swaps only on strictly larger).
    function automatic mhpq_out_t predict_heap_op(input mhpq_in_t beat);
        mhpq_out_t               res;
        int                      pos;
        int                      parent;
        int                      best;
        int                      lchild;
        int                      rchild;
        logic signed [KEY_W-1:0] tmp;
        res.max_key = '0;
        res.status  = ST_OK;
        if (beat.operation == OPER_INSERT)
        begin
            if (heap_model_fill >= DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                heap_model_keys[heap_model_fill] = beat.key;
                heap_model_fill++;
                pos = heap_model_fill - 1;
                while (pos != 0)
                begin
                    parent = (pos - 1) / 2;
                    if (heap_model_keys[pos] <= heap_model_keys[parent])
                        break;
                    tmp = heap_model_keys[pos];
                    heap_model_keys[pos] = heap_model_keys[parent];
                    heap_model_keys[parent] = tmp;
                    pos = parent;
                end
            end
        end
        else
        begin
            if (heap_model_fill == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.max_key = heap_model_keys[0];
                heap_model_fill--;
                if (heap_model_fill > 0)
                begin
                    heap_model_keys[0] = heap_model_keys[heap_model_fill];
                    pos = 0;
                    forever
                    begin
                        best   = pos;
                        lchild = 2 * pos + 1;
                        rchild = 2 * pos + 2;
                        if (lchild < heap_model_fill &&
                            heap_model_keys[lchild] > heap_model_keys[best])
                            best = lchild;
                        if (rchild < heap_model_fill &&
                            heap_model_keys[rchild] > heap_model_keys[best])
                            best = rchild;
                        if (best == pos)
                            break;
                        tmp = heap_model_keys[pos];
                        heap_model_keys[pos] = heap_model_keys[best];
                        heap_model_keys[best] = tmp;
                        pos = best;
                    end
                end
            end
        end
        res.fill_count = FILL_W'(heap_model_fill);
        return res;
    endfunction

    // Key mix: full-range random, extremes, and a narrow band to force ties.
    function automatic logic [KEY_W-1:0] pick_key();
        int v;
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3:
            begin
                v = int'($urandom_range(0, 15)) - 8;
                return v;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic push_op(input logic op, input logic [KEY_W-1:0] k);
        mhpq_in_t beat;
        beat.operation = op;
        beat.key       = k;
        pending_ops.push_back(beat);
        if (op == OPER_INSERT && gen_fill < DEPTH)
            gen_fill++;
        else if (op == OPER_EXTRACT && gen_fill > 0)
            gen_fill--;
    endtask

    task automatic push_random_op(input int insert_pct);
        logic op;
        op = ($urandom_range(1, 100) <= insert_pct) ? OPER_INSERT : OPER_EXTRACT;
        push_op(op, pick_key());
    endtask

    // Sender: bursts of random length, random gaps between them, and now and
    // then a long back-to-back stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_ops.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_ops.pop_front();
                if (burst_left <= 1)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        burst_left <= 48;
                        gap_left   <= 0;
                    end
                    else
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= $urandom_range(0, 15);
                    end
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern is picked at random each time rx_timer wraps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_mode   <= RX_ALWAYS;
            rx_timer  <= 0;
        end
        else
        begin
            if (rx_timer == 199)
            begin
                rx_timer <= 0;
                rx_mode  <= rx_mode_t'($urandom_range(0, 3));
            end
            else
            begin
                rx_timer <= rx_timer + 1;
            end
            case (rx_mode)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_MOSTLY: out_ready <= ($urandom_range(0, 9) < 7);
                RX_PERIOD: out_ready <= (rx_timer[1:0] == 2'd0);
                default:   out_ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    // Monitor: predict on each accepted input beat, check each output beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_heap_op(in_data));

            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] unexpected result beat: ", $realtime,
                                 "max_key=%0d status=%0d fill=%0d",
                                 out_data.max_key, out_data.status,
                                 out_data.fill_count);
                end
                else
                begin
                    mhpq_out_t exp_beat;
                    exp_beat = expected_results.pop_front();
                    if (out_data.max_key !== exp_beat.max_key ||
                        out_data.status !== exp_beat.status ||
                        out_data.fill_count !== exp_beat.fill_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("[%0t] mismatch: ", $realtime,
                                     "max_key exp %0d got %0d, ",
                                     exp_beat.max_key, out_data.max_key,
                                     "status exp %0d got %0d, ",
                                     exp_beat.status, out_data.status,
                                     "fill exp %0d got %0d",
                                     exp_beat.fill_count, out_data.fill_count);
                    end
                end
            end

            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        gen_fill        = 0;
        mismatch_count  = 0;
        heap_model_fill = 0;
        idle_cycles     = 0;

        // directed: empty extract, single key, extremes, duplicates, ordered drain
        push_op(OPER_EXTRACT, 32'hFFFF_FFFF);
        push_op(OPER_INSERT, 32'h0000_0000);
        push_op(OPER_EXTRACT, 32'h0000_0000);
        push_op(OPER_EXTRACT, 32'h0000_0000);
        push_op(OPER_INSERT, 32'h8000_0000);
        push_op(OPER_INSERT, 32'h7FFF_FFFF);
        push_op(OPER_INSERT, 32'hFFFF_FFFF);
        push_op(OPER_INSERT, 32'h0000_0001);
        push_op(OPER_INSERT, 32'h0000_0000);
        push_op(OPER_INSERT, 32'h8000_0000);
        push_op(OPER_INSERT, 32'h7FFF_FFFF);
        push_op(OPER_INSERT, 32'h0000_0005);
        push_op(OPER_INSERT, 32'h0000_0005);
        repeat (9)
            push_op(OPER_EXTRACT, 32'h5555_AAAA);
        push_op(OPER_EXTRACT, 32'hAAAA_5555);

        // random mix around small fills, empties included
        repeat (120)
            push_random_op(50);
        // fill to capacity
        while (gen_fill < DEPTH)
            push_random_op(97);
        // dither at full: overflow inserts and a few extracts
        repeat (40)
            push_random_op(75);
        // deep sift-down work on a large heap
        while (gen_fill > 700)
            push_random_op(10);
        repeat (60)
            push_random_op(50);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
